// File: design/mts_pkg.sv
// Shared constants, types and codes of the min-tracking stack.
package mts_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W     = 2 * DATA_W;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_POP_READ
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] min_value;
        logic                     is_empty;
        t_status                  status;
        logic [CNT_W-1:0]         fill_count;
    } t_result;

endpackage

// File: design/mts_req_if.sv
// Request channel: valid/ready handshake carrying mode and push value.
interface mts_req_if
    import mts_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink   (input valid, input mode, input push_value, output ready);
endinterface

// File: design/mts_rsp_if.sv
// Response channel: valid/ready handshake carrying the stack report.
interface mts_rsp_if
    import mts_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic                     is_empty;
    logic [1:0]               status;
    logic [CNT_W-1:0]         fill_count;

    modport source (output valid, output top_value, output min_value, output is_empty,
                    output status, output fill_count, input ready);
    modport sink   (input valid, input top_value, input min_value, input is_empty,
                    input status, input fill_count, output ready);
endinterface

// File: design/mts_ram.sv
// Generic simple dual-port RAM with registered read.
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/mts_core.sv
// Stack engine: cached top entry, entry count and the backing entry memory.
module mts_core
    import mts_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic                     i_mode,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                     o_busy,
    output logic                     o_res_valid,
    output t_result                  o_res
);
    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic signed [DATA_W-1:0] r_top_val, n_top_val;
    logic signed [DATA_W-1:0] r_top_min, n_top_min;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]       ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]       ram_rdata;
    logic signed [DATA_W-1:0] push_min;
    t_status                  status;

    mts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_top_val <= n_top_val;
        r_top_min <= n_top_min;
    end

    // new entry minimum: own value on an empty stack, else the smaller one
    assign push_min = (r_count != '0 && !(i_push_value < r_top_min)) ? r_top_min
                                                                     : i_push_value;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_top_val   = r_top_val;
        n_top_min   = r_top_min;
        ram_we      = 1'b0;
        ram_waddr   = r_count[ADDR_W-1:0];
        ram_wdata   = {push_min, i_push_value};
        // entry that becomes the top after a pop
        ram_raddr   = ADDR_W'(r_count - CNT_W'(2));
        o_res_valid = 1'b0;
        status      = STAT_DONE;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    if (i_mode == MODE_POP) begin
                        if (r_count == '0) begin
                            status      = STAT_UNDERFLOW;
                            o_res_valid = 1'b1;
                        end else begin
                            n_count = r_count - CNT_W'(1);
                            n_state = S_POP_READ;
                        end
                    end else begin
                        if (r_count == FULL_COUNT) begin
                            status      = STAT_OVERFLOW;
                            o_res_valid = 1'b1;
                        end else begin
                            ram_we      = 1'b1;
                            n_top_val   = i_push_value;
                            n_top_min   = push_min;
                            n_count     = r_count + CNT_W'(1);
                            o_res_valid = 1'b1;
                        end
                    end
                end
            end
            S_POP_READ: begin
                n_top_val   = ram_rdata[DATA_W-1:0];
                n_top_min   = ram_rdata[ENTRY_W-1:DATA_W];
                o_res_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_res.is_empty   = (n_count == '0);
        o_res.top_value  = o_res.is_empty ? '0 : n_top_val;
        o_res.min_value  = o_res.is_empty ? '0 : n_top_min;
        o_res.status     = status;
        o_res.fill_count = n_count;
    end
endmodule

// File: design/min_tracking_stack_unit.sv
// Min-tracking stack: top level with request handshake and result register.
// Push, overflow and underflow: result valid in the cycle after the transaction.
// Pop: the entry memory is read in S_POP_READ, then the report goes to the result register.
// Throughput: one push per cycle while the sink takes each result; a pop blocks new requests until its read is done.
// Reset clears the entry count and handshake state; the entry memory is not
// cleared, since entries at or above the count never reach a report. No clearing pass.
module min_tracking_stack_unit
    import mts_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    mts_req_if.sink   i_req,
    mts_rsp_if.source o_rsp
);
    logic    core_busy;
    logic    core_res_valid;
    t_result core_res;
    logic    accept;
    logic    r_out_valid;
    t_result r_out;

    // take a request when the engine is idle and the result slot frees up
    assign i_req.ready = !core_busy && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;

    mts_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_mode       (i_req.mode),
        .i_push_value (i_req.push_value),
        .o_busy       (core_busy),
        .o_res_valid  (core_res_valid),
        .o_res        (core_res)
    );

    // result register: load a fresh report, hold it until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (core_res_valid) begin
            r_out <= core_res;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.top_value  = r_out.top_value;
    assign o_rsp.min_value  = r_out.min_value;
    assign o_rsp.is_empty   = r_out.is_empty;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.fill_count = r_out.fill_count;
endmodule
